// ===== rtl/vcsd_pkg.sv =====
// ============================================================================
// Voxel column span decoder - shared definitions
// Map geometry, field widths, the fill color and the command and status
// records exchanged between the sequencer and the datapath.
// ============================================================================
package vcsd_pkg;

    localparam int MAP_SIDE    = 512;
    localparam int MAP_HEIGHT  = 64;

    // Column cursor and height iterator widths follow from the map geometry.
    localparam int CUR_W       = $clog2(MAP_SIDE);
    localparam int HT_W        = $clog2(MAP_HEIGHT + 1);

    // Output field widths.
    localparam int XY_W        = 9;
    localparam int Z_W         = 6;
    localparam int COL_W       = 8;

    // Byte position inside a span; a final span can run up to 1028 bytes.
    localparam int POS_W       = 11;

    // Bottom color buffer.
    localparam int BOT_DEPTH   = 64;
    localparam int BOT_AW      = $clog2(BOT_DEPTH);

    // At most this many voxel writes come from one input byte.
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Stream widths.
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 48;
    localparam int M_TUSER_W   = 2;

    // Color of solid voxels below the surface.
    localparam logic [COL_W-1:0] FILL_RED   = 8'd91;
    localparam logic [COL_W-1:0] FILL_GREEN = 8'd64;
    localparam logic [COL_W-1:0] FILL_BLUE  = 8'd64;

    // Height runs that a span header can trigger, in emission order.
    typedef enum logic [1:0] {
        PH_BOT  = 2'd0,
        PH_FILL = 2'd1,
        PH_FIN  = 2'd2
    } phase_t;

    typedef struct packed {
        logic   capture;     // take the input beat and step the span state
        logic   prep;        // work out the height bounds of the pending runs
        logic   h_load;      // start a run at its lower bound
        phase_t load_phase;  // run that h_load starts
        logic   h_inc;       // move to the next height of the current run
        phase_t phase;       // run that is being emitted
        logic   emit;        // load one voxel into the output register
        logic   emit_top;    // the voxel is the single top-run color
        logic   emit_last;   // the voxel closes the results of this beat
    } vcsd_cmd_t;

    typedef struct packed {
        logic top_job;   // the beat being offered completes a top color
        logic span_job;  // the beat being offered resolves a run or ends a column
        logic b_ne;      // bottom run has heights inside the map
        logic f_ne;      // solid fill under the pending span is not empty
        logic n_ne;      // final fill down to the floor is not empty
        logic at_end;    // current height is the last one of its run
        logic cnt_max;   // the next voxel is the last one allowed for this beat
        logic out_free;  // output register can take a voxel this cycle
    } vcsd_stat_t;

endpackage

// ===== rtl/vcsd_dp.sv =====
// ============================================================================
// Voxel column span decoder - datapath
// Span parsing state, column cursor, bottom color buffer, height iterator
// and the output register of the voxel write channel.
// ============================================================================
module vcsd_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [vcsd_pkg::S_TDATA_W-1:0] in_byte,
    input  logic                           in_restart,
    input  vcsd_pkg::vcsd_cmd_t            cmd,
    output vcsd_pkg::vcsd_stat_t           st,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [vcsd_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    output logic [vcsd_pkg::M_TUSER_W-1:0] m_tuser
);
    import vcsd_pkg::*;

    // Span and cursor state.
    logic [POS_W-1:0] pos_reg;
    logic [7:0]       len_reg, ts_reg, te_reg, pbc_reg, pte_reg, cc_reg;
    logic             pv_reg, done_reg;
    logic [15:0]      part_reg;
    logic [CUR_W-1:0] cx_reg, cy_reg;

    // State as seen by the beat: a restart clears it first.
    logic [POS_W-1:0] pos_e;
    logic [7:0]       len_e, ts_e, te_e, pbc_e, pte_e, cc_e;
    logic             pv_e, done_e;
    logic [15:0]      part_e;
    logic [CUR_W-1:0] cx_e, cy_e;

    // State after the beat.
    logic [POS_W-1:0] pos_s;
    logic [7:0]       len_s, ts_s, te_s, pbc_s, pte_s, cc_s;
    logic             pv_s, done_s;
    logic [15:0]      part_s;
    logic [CUR_W-1:0] cx_s, cy_s;

    logic             top_go, res_go, fin_go, bot_we;
    logic signed [9:0] k_raw;
    logic [8:0]       tc;
    logic [8:0]       top_sum;
    logic [POS_W-1:0] pos_inc, span_len;

    // Work captured from the beat for the emission sequence.
    logic [CUR_W-1:0]     job_cx_reg, job_cy_reg;
    logic                 job_done_reg, job_res_reg, job_fin_reg;
    logic [HT_W-1:0]      job_top_h_reg;
    logic [3*COL_W-1:0]   job_rgb_reg;
    logic [7:0]           job_m_reg, job_z_reg, job_pte_reg, job_te_reg;

    // Run bounds, set up once per header.
    logic [HT_W-1:0]      lo_b_reg, hi_b_reg, lo_f_reg, lo_n_reg;
    logic                 b_ne_reg, f_ne_reg, n_ne_reg;
    logic [BOT_AW-1:0]    off_reg;
    logic signed [9:0]    mz;

    logic [HT_W-1:0]      h_reg, h_next, lo_sel, hi_sel, h_emit;
    logic [CNT_W-1:0]     emit_cnt_reg;

    logic [3*COL_W-1:0]   bot_mem [BOT_DEPTH];
    logic [3*COL_W-1:0]   bot_rd_reg;
    logic [BOT_AW-1:0]    rd_addr;

    logic                 out_valid_reg, out_last_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TUSER_W-1:0] out_user_reg;
    logic [CUR_W-1:0]     mx;
    logic [COL_W-1:0]     red_sel, green_sel, blue_sel;
    logic                 solid_sel;
    logic [Z_W-1:0]       vz;

    function automatic logic [HT_W-1:0] clamp_h(input logic signed [9:0] v);
        logic [HT_W-1:0] r;
        if (v < 10'sd0) begin
            r = '0;
        end else if (v > 10'(MAP_HEIGHT)) begin
            r = HT_W'(MAP_HEIGHT);
        end else begin
            r = HT_W'(v);
        end
        return r;
    endfunction

    assign pos_e  = in_restart ? '0 : pos_reg;
    assign len_e  = in_restart ? '0 : len_reg;
    assign ts_e   = in_restart ? '0 : ts_reg;
    assign te_e   = in_restart ? '0 : te_reg;
    assign pbc_e  = in_restart ? '0 : pbc_reg;
    assign pte_e  = in_restart ? '0 : pte_reg;
    assign cc_e   = in_restart ? '0 : cc_reg;
    assign pv_e   = in_restart ? 1'b0 : pv_reg;
    assign done_e = in_restart ? 1'b0 : done_reg;
    assign part_e = in_restart ? '0 : part_reg;
    assign cx_e   = in_restart ? '0 : cx_reg;
    assign cy_e   = in_restart ? '0 : cy_reg;

    // Number of top-run color words, clipped to the words the span holds.
    assign k_raw = $signed({2'b00, te_e}) - $signed({2'b00, ts_e}) + 10'sd1;
    always_comb begin
        if (k_raw < 10'sd0) begin
            tc = '0;
        end else if (len_e != 8'd0 && k_raw > $signed({2'b00, len_e}) - 10'sd1) begin
            tc = {1'b0, len_e} - 9'd1;
        end else begin
            tc = k_raw[8:0];
        end
    end

    assign top_sum  = {1'b0, ts_e} + {1'b0, cc_e};
    assign pos_inc  = pos_e + POS_W'(1);
    assign span_len = (len_e == 8'd0) ? POS_W'({tc, 2'b00}) + POS_W'(4)
                                      : POS_W'({len_e, 2'b00});

    always_comb begin
        pos_s  = pos_e;
        len_s  = len_e;
        ts_s   = ts_e;
        te_s   = te_e;
        pbc_s  = pbc_e;
        pte_s  = pte_e;
        pv_s   = pv_e;
        part_s = part_e;
        cc_s   = cc_e;
        cx_s   = cx_e;
        cy_s   = cy_e;
        done_s = done_e;
        top_go = 1'b0;
        res_go = 1'b0;
        fin_go = 1'b0;
        bot_we = 1'b0;
        if (!done_e) begin
            if (pos_e == POS_W'(0)) begin
                len_s = in_byte;
            end else if (pos_e == POS_W'(1)) begin
                ts_s = in_byte;
            end else if (pos_e == POS_W'(2)) begin
                te_s = in_byte;
            end else if (pos_e == POS_W'(3)) begin
                // The air-start byte settles the previous span's bottom run.
                res_go = pv_e;
                pv_s   = 1'b0;
                pbc_s  = '0;
                cc_s   = '0;
                part_s = '0;
            end else begin
                case (pos_e[1:0])
                    2'd0: begin
                        part_s = {8'h00, in_byte};
                    end
                    2'd1: begin
                        part_s = {in_byte, part_e[7:0]};
                    end
                    2'd2: begin
                        if ({1'b0, cc_e} < tc) begin
                            top_go = (top_sum < 9'(MAP_HEIGHT));
                        end else begin
                            bot_we = 1'b1;
                            if (pbc_e != 8'hff) begin
                                pbc_s = pbc_e + 8'd1;
                            end
                        end
                    end
                    default: begin
                        cc_s = cc_e + 8'd1;
                    end
                endcase
            end

            if (pos_inc <= POS_W'(3)) begin
                pos_s = pos_inc;
            end else if (pos_inc >= span_len) begin
                pos_s = '0;
                if (len_e == 8'd0) begin
                    fin_go = 1'b1;
                    if (cx_e == CUR_W'(MAP_SIDE - 1)) begin
                        cx_s   = '0;
                        cy_s   = cy_e + CUR_W'(1);
                        done_s = (cy_e == CUR_W'(MAP_SIDE - 1));
                    end else begin
                        cx_s = cx_e + CUR_W'(1);
                    end
                end else begin
                    pv_s  = 1'b1;
                    pte_s = te_e;
                end
            end else begin
                pos_s = pos_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            len_reg  <= '0;
            ts_reg   <= '0;
            te_reg   <= '0;
            pbc_reg  <= '0;
            pte_reg  <= '0;
            cc_reg   <= '0;
            pv_reg   <= 1'b0;
            done_reg <= 1'b0;
            part_reg <= '0;
            cx_reg   <= '0;
            cy_reg   <= '0;
        end else if (cmd.capture) begin
            pos_reg  <= pos_s;
            len_reg  <= len_s;
            ts_reg   <= ts_s;
            te_reg   <= te_s;
            pbc_reg  <= pbc_s;
            pte_reg  <= pte_s;
            cc_reg   <= cc_s;
            pv_reg   <= pv_s;
            done_reg <= done_s;
            part_reg <= part_s;
            cx_reg   <= cx_s;
            cy_reg   <= cy_s;
        end
    end

    // All voxels of a beat carry the cursor from before the beat.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            job_cx_reg    <= cx_e;
            job_cy_reg    <= cy_e;
            job_done_reg  <= done_s;
            job_res_reg   <= res_go;
            job_fin_reg   <= fin_go;
            job_top_h_reg <= HT_W'(top_sum);
            job_rgb_reg   <= {in_byte, part_e[15:8], part_e[7:0]};
            job_m_reg     <= in_byte;
            job_z_reg     <= pbc_e;
            job_pte_reg   <= pte_e;
            job_te_reg    <= te_e;
        end
    end

    // Bottom run sits at m-z .. m-1, solid fill below it down to the old
    // top end, and a final span fills from its top end to the floor.
    assign mz = $signed({2'b00, job_m_reg}) - $signed({2'b00, job_z_reg});

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            lo_b_reg <= clamp_h(mz);
            hi_b_reg <= clamp_h($signed({2'b00, job_m_reg}));
            lo_f_reg <= clamp_h($signed({2'b00, job_pte_reg}) + 10'sd1);
            lo_n_reg <= clamp_h($signed({2'b00, job_te_reg}) + 10'sd1);
            b_ne_reg <= job_res_reg && (clamp_h(mz) < clamp_h($signed({2'b00, job_m_reg})));
            f_ne_reg <= job_res_reg
                        && (clamp_h($signed({2'b00, job_pte_reg}) + 10'sd1) < clamp_h(mz));
            n_ne_reg <= job_fin_reg
                        && (clamp_h($signed({2'b00, job_te_reg}) + 10'sd1)
                            < HT_W'(MAP_HEIGHT));
            off_reg  <= BOT_AW'(job_z_reg) - BOT_AW'(job_m_reg);
        end
    end

    always_comb begin
        case (cmd.load_phase)
            PH_BOT:  lo_sel = lo_b_reg;
            PH_FILL: lo_sel = lo_f_reg;
            default: lo_sel = lo_n_reg;
        endcase
        case (cmd.phase)
            PH_BOT:  hi_sel = hi_b_reg;
            PH_FILL: hi_sel = lo_b_reg;
            default: hi_sel = HT_W'(MAP_HEIGHT);
        endcase
    end

    always_comb begin
        if (cmd.h_load) begin
            h_next = lo_sel;
        end else if (cmd.h_inc) begin
            h_next = h_reg + HT_W'(1);
        end else begin
            h_next = h_reg;
        end
    end

    always_ff @(posedge aclk) begin
        h_reg <= h_next;
    end

    // The buffer is addressed with the next height and its read is registered like
    // h_reg, so its data lines up with h_reg, also while the output stalls.
    assign rd_addr = BOT_AW'(h_next) + off_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture && bot_we) begin
            bot_mem[pbc_e[BOT_AW-1:0]] <= {in_byte, part_e[15:8], part_e[7:0]};
        end
        bot_rd_reg <= bot_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_cnt_reg <= '0;
        end else if (cmd.capture) begin
            emit_cnt_reg <= '0;
        end else if (cmd.emit) begin
            emit_cnt_reg <= emit_cnt_reg + CNT_W'(1);
        end
    end

    // Voxel assembly.
    assign mx     = CUR_W'(MAP_SIDE - 1) - job_cx_reg;
    assign h_emit = cmd.emit_top ? job_top_h_reg : h_reg;
    assign vz     = Z_W'(HT_W'(MAP_HEIGHT - 1) - h_emit);

    always_comb begin
        if (cmd.emit_top) begin
            {red_sel, green_sel, blue_sel} = job_rgb_reg;
            solid_sel = 1'b0;
        end else if (cmd.phase == PH_BOT) begin
            {red_sel, green_sel, blue_sel} = bot_rd_reg;
            solid_sel = 1'b0;
        end else begin
            red_sel   = FILL_RED;
            green_sel = FILL_GREEN;
            blue_sel  = FILL_BLUE;
            solid_sel = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_data_reg <= {blue_sel, green_sel, red_sel, vz,
                             XY_W'(job_cy_reg), XY_W'(mx)};
            out_user_reg <= {job_done_reg, solid_sel};
            out_last_reg <= cmd.emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    assign st.top_job  = top_go;
    assign st.span_job = res_go || fin_go;
    assign st.b_ne     = b_ne_reg;
    assign st.f_ne     = f_ne_reg;
    assign st.n_ne     = n_ne_reg;
    assign st.at_end   = (HT_W'(h_reg + HT_W'(1)) == hi_sel);
    assign st.cnt_max  = (emit_cnt_reg == CNT_W'(MAX_RESULTS - 1));
    assign st.out_free = !out_valid_reg || m_tready;

    a_emit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!out_valid_reg || m_tready))
        else $error("voxel loaded while the output register is held");

    a_bot_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && !cmd.emit_top && cmd.phase == PH_BOT)
            |-> (h_reg >= lo_b_reg && h_reg < hi_b_reg))
        else $error("bottom run height outside its bounds");

    a_emit_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (emit_cnt_reg < CNT_W'(MAX_RESULTS)))
        else $error("more voxels than allowed for one beat");

    a_inc_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.h_inc |-> !st.at_end)
        else $error("height stepped past the end of its run");

endmodule

// ===== rtl/vcsd_ctrl.sv =====
// ============================================================================
// Voxel column span decoder - sequencer
// Takes input beats and walks the top, bottom, fill and final runs that a
// beat triggers, one voxel per cycle while the output accepts.
// ============================================================================
module vcsd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  vcsd_pkg::vcsd_stat_t  st,
    output vcsd_pkg::vcsd_cmd_t   cmd
);
    import vcsd_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_TOP  = 7'b0000010,
        S_PREP = 7'b0000100,
        S_LOAD = 7'b0001000,
        S_BOT  = 7'b0010000,
        S_FILL = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.phase      = PH_BOT;
        cmd.load_phase = PH_BOT;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    if (st.top_job) begin
                        state_next = S_TOP;
                    end else if (st.span_job) begin
                        state_next = S_PREP;
                    end
                end
            end
            S_TOP: begin
                cmd.emit_top = 1'b1;
                if (st.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_PREP: begin
                cmd.prep   = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                if (st.b_ne) begin
                    cmd.h_load     = 1'b1;
                    cmd.load_phase = PH_BOT;
                    state_next     = S_BOT;
                end else if (st.f_ne) begin
                    cmd.h_load     = 1'b1;
                    cmd.load_phase = PH_FILL;
                    state_next     = S_FILL;
                end else if (st.n_ne) begin
                    cmd.h_load     = 1'b1;
                    cmd.load_phase = PH_FIN;
                    state_next     = S_FIN;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_BOT: begin
                cmd.phase = PH_BOT;
                if (st.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = st.cnt_max || (st.at_end && !st.f_ne && !st.n_ne);
                    if (cmd.emit_last) begin
                        state_next = S_IDLE;
                    end else if (st.at_end) begin
                        cmd.h_load = 1'b1;
                        if (st.f_ne) begin
                            cmd.load_phase = PH_FILL;
                            state_next     = S_FILL;
                        end else begin
                            cmd.load_phase = PH_FIN;
                            state_next     = S_FIN;
                        end
                    end else begin
                        cmd.h_inc = 1'b1;
                    end
                end
            end
            S_FILL: begin
                cmd.phase = PH_FILL;
                if (st.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = st.cnt_max || (st.at_end && !st.n_ne);
                    if (cmd.emit_last) begin
                        state_next = S_IDLE;
                    end else if (st.at_end) begin
                        cmd.h_load     = 1'b1;
                        cmd.load_phase = PH_FIN;
                        state_next     = S_FIN;
                    end else begin
                        cmd.h_inc = 1'b1;
                    end
                end
            end
            S_FIN: begin
                cmd.phase = PH_FIN;
                if (st.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = st.cnt_max || st.at_end;
                    if (cmd.emit_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.h_inc = 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    a_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.emit_last) |=> s_tready)
        else $error("input not taken after the last voxel of a beat");

    a_top_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.capture && st.top_job) |=> (cmd.emit_top && !cmd.h_load && !cmd.prep))
        else $error("top color beat did not go straight to its voxel");

endmodule

// ===== rtl/voxel_column_span_decoder_core.sv =====
// ============================================================================
// Voxel column span decoder
// Decodes a span-coded voxel column map, one file byte per input beat, into
// a stream of voxel writes with mirrored x and height.
// ============================================================================
// Input channel (s_): one map file byte per beat in s_tdata; s_tuser set on
// a beat clears the cursor and span state before that byte is taken.
// Output channel (m_): one voxel write per beat; m_tlast marks the last voxel
// caused by an input byte; m_tuser carries the solid-fill and map-done flags.
// Flow: a byte that starts no run is taken while the sequencer stays idle; a
// byte that completes a top-run color inside the map writes that single voxel.
// An air-start byte that settles a pending bottom run, or a column-ending
// byte, passes the prep and load states even when it writes no voxel, then
// writes up to 64 voxels as the sequencer walks bottom run, solid fill and
// final fill through a single output register. Bottom colors come from a
// 64-entry buffer addressed by the next height, ready for the voxel using them.
// When the receiver stalls, the sequencer holds its height and waits; new
// bytes are taken again once the last voxel of a byte sits in the output
// register, even if that voxel has not been taken yet.
// Reset clears cursor, span state and the output valid; the bottom color
// buffer holds no defined contents and needs no clearing pass.
module voxel_column_span_decoder_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [vcsd_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] in_byte
    input  logic [0:0]                     s_tuser,   // [0] restart
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [vcsd_pkg::M_TDATA_W-1:0] m_tdata,   // vox_x, vox_y, vox_z, red, green, blue
    output logic                           m_tlast,   // last voxel of the input byte
    output logic [vcsd_pkg::M_TUSER_W-1:0] m_tuser    // [0] solid_fill, [1] map_done
);
    import vcsd_pkg::*;

    vcsd_cmd_t  cmd;
    vcsd_stat_t st;

    vcsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    vcsd_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_byte    (s_tdata),
        .in_restart (s_tuser[0]),
        .cmd        (cmd),
        .st         (st),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule
